// ===== rtl/core/sdssf_pkg.sv =====
// shared constants and helper functions for the signed decimal seven segment formatter
package sdssf_pkg;

  // display geometry and number format
  localparam int DIGIT_COUNT = 4;
  localparam int FRAC_BITS   = 16;
  localparam int VALUE_W     = 32;
  localparam int ROW_W       = 2;
  localparam int INT_W       = VALUE_W - FRAC_BITS;
  localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int CNT_W       = POS_W + 1;
  localparam int BCD_W       = 4;
  localparam int SEG_W       = 8;
  localparam int COL_LOW_W   = 8;
  localparam int COL_HIGH_W  = 4;
  localparam int DPOS_W      = 2;
  localparam int WIDE_W      = 40;

  // stream payload widths
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 24;

  // display rows
  localparam logic [ROW_W-1:0] ROW_LOW     = 2'd0;
  localparam logic [ROW_W-1:0] ROW_MID     = 2'd1;
  localparam logic [ROW_W-1:0] ROW_HIGH    = 2'd2;
  localparam logic [ROW_W-1:0] ROW_INVALID = 2'd3;

  // special segment patterns (active low)
  localparam logic [SEG_W-1:0] SEG_MINUS      = 8'hbf;
  localparam logic [SEG_W-1:0] SEG_POINT_MASK = 8'h7f;
  localparam logic [SEG_W-1:0] SEG_BLANK      = 8'hff;

  typedef logic [SEG_W-1:0] seg_t;
  typedef logic [BCD_W-1:0] bcd_t;

  // power of ten, used only with constant arguments
  function automatic logic [WIDE_W-1:0] pow10(input int n);
    logic [WIDE_W-1:0] acc;
    acc = WIDE_W'(1);
    for (int i = 0; i < n; i++) begin
      acc = acc * WIDE_W'(10);
    end
    return acc;
  endfunction

  // decimal digit to active-low segment pattern
  function automatic seg_t seg_of(input bcd_t d);
    seg_t s;
    case (d)
      4'd0:    s = 8'hc0;
      4'd1:    s = 8'hf9;
      4'd2:    s = 8'ha4;
      4'd3:    s = 8'hb0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hf8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/signed_decimal_seven_segment_formatter_unit.sv =====
// top level: signed fixed-point value to four seven-segment position transactions
//
//   channel | direction | payload                                  | per value
//   --------+-----------+------------------------------------------+-----------------
//   in_*    | slave     | tuser: row, tdata: value                 | one transaction
//   out_*   | master    | tdata: position/enables/segments, tlast  | DIGIT_COUNT or none
//
// an accepted value lands in the input register; the whole formatting (sign,
// decimal digits, fraction digits, segment lookup) is done combinationally and
// written to the result register once it is free; that register then issues
// one position per cycle while out_tready is high, DIGIT_COUNT per value (4 by
// default); the output serializer is the bottleneck, while the input register
// already holds the next value. dropped values (invalid row, overflow) are not sent.
// reset is synchronous, active low, and clears valid flags and the position
// counter; backpressure on out_tready holds the current position and fills
// the input register before in_tready falls
module signed_decimal_seven_segment_formatter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sdssf_pkg::IN_DATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic [sdssf_pkg::ROW_W-1:0]       in_tuser,   // [1:0] row
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sdssf_pkg::OUT_DATA_W-1:0]  out_tdata,  // [1:0] digit_position,
                                                        // [9:2] column_enable_low,
                                                        // [13:10] column_enable_high,
                                                        // [21:14] segments, [23:22] zero
  output logic                              out_tlast   // last position of the value
);
  import sdssf_pkg::*;

  // input register
  logic                 a_valid_r, a_valid_nxt;
  logic [VALUE_W-1:0]   a_value_r;
  logic [ROW_W-1:0]     a_row_r;

  // result register
  logic                 b_valid_r, b_valid_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [ROW_W-1:0]     b_row_r;
  seg_t                 segs_r [DIGIT_COUNT];

  // formatting logic
  logic                 neg;
  logic [VALUE_W-1:0]   mag;
  logic [INT_W-1:0]     ipart;
  logic [FRAC_BITS-1:0] frac;
  logic                 drop;
  bcd_t                 idig [DIGIT_COUNT];
  bcd_t                 fdig [DIGIT_COUNT];
  logic [CNT_W-1:0]     ndig;
  seg_t                 segs_nxt [DIGIT_COUNT];

  // handshake control
  logic                 out_fire;
  logic                 out_done;
  logic                 b_free;
  logic                 a_move;
  logic                 b_load;

  assign out_fire  = out_tvalid && out_tready;
  assign out_done  = out_fire && (pos_r == POS_W'(DIGIT_COUNT - 1));
  assign b_free    = !b_valid_r || out_done;
  assign a_move    = a_valid_r && (drop || b_free);
  assign b_load    = a_valid_r && !drop && b_free;
  assign in_tready = !a_valid_r || a_move;

  // integer and fraction split of the magnitude
  always_comb begin
    neg   = a_value_r[VALUE_W-1];
    mag   = neg ? (~a_value_r + VALUE_W'(1)) : a_value_r;
    ipart = mag[VALUE_W-1:FRAC_BITS];
    frac  = mag[FRAC_BITS-1:0];
  end

  // decimal digits of the integer part, one compare-subtract per place
  always_comb begin
    logic [WIDE_W-1:0] rem;
    logic [WIDE_W-1:0] sub;
    bcd_t              d;
    rem = WIDE_W'(ipart);
    for (int p = DIGIT_COUNT - 1; p >= 0; p--) begin
      d   = '0;
      sub = '0;
      for (int m = 1; m < 10; m++) begin
        if (rem >= WIDE_W'(m) * pow10(p)) begin
          d   = BCD_W'(m);
          sub = WIDE_W'(m) * pow10(p);
        end
      end
      idig[p] = d;
      rem     = rem - sub;
    end
  end

  // count of integer digits, at least one so a zero integer part shows "0."
  always_comb begin
    ndig = CNT_W'(1);
    for (int p = 0; p < DIGIT_COUNT; p++) begin
      if (idig[p] != '0) begin
        ndig = CNT_W'(p + 1);
      end
    end
  end

  // truncated fraction digits: times ten, peel off the integer bits
  always_comb begin
    logic [FRAC_BITS-1:0] f;
    logic [FRAC_BITS+3:0] t;
    f = frac;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      t       = {3'b000, f, 1'b0} + {1'b0, f, 3'b000};
      fdig[i] = t[FRAC_BITS+3:FRAC_BITS];
      f       = t[FRAC_BITS-1:0];
    end
  end

  // overflow and invalid row checks
  always_comb begin
    drop = (a_row_r == ROW_INVALID)
        || (WIDE_W'(ipart) >= pow10(DIGIT_COUNT))
        || (neg && (WIDE_W'(ipart) >= pow10(DIGIT_COUNT - 1)));
  end

  // character for each position: optional minus, integer digits, fraction digits
  always_comb begin
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] place;
    logic [CNT_W-1:0] fidx;
    for (int y = 0; y < DIGIT_COUNT; y++) begin
      k     = CNT_W'(y) - CNT_W'(neg);
      place = ndig - CNT_W'(1) - k;
      fidx  = k - ndig;
      if (neg && (y == 0)) begin
        segs_nxt[y] = SEG_MINUS;
      end else if (k < ndig) begin
        segs_nxt[y] = seg_of(idig[place[POS_W-1:0]]);
        if (k == ndig - CNT_W'(1)) begin
          segs_nxt[y] = segs_nxt[y] & SEG_POINT_MASK;
        end
      end else begin
        segs_nxt[y] = seg_of(fdig[fidx[POS_W-1:0]]);
      end
    end
  end

  // valid flags and position counter
  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_tvalid && in_tready) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end

    b_valid_nxt = b_valid_r;
    pos_nxt     = pos_r;
    if (b_load) begin
      b_valid_nxt = 1'b1;
      pos_nxt     = '0;
    end else if (out_done) begin
      b_valid_nxt = 1'b0;
      pos_nxt     = '0;
    end else if (out_fire) begin
      pos_nxt     = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      pos_r     <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      pos_r     <= pos_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_value_r <= in_tdata;
      a_row_r   <= in_tuser;
    end
    if (b_load) begin
      b_row_r <= a_row_r;
      for (int y = 0; y < DIGIT_COUNT; y++) begin
        segs_r[y] <= segs_nxt[y];
      end
    end
  end

  // column enables for the current position, active low
  always_comb begin
    logic [COL_LOW_W-1:0]  col_low;
    logic [COL_HIGH_W-1:0] col_high;
    col_low  = '1;
    col_high = '1;
    for (int b = 0; b < COL_LOW_W; b++) begin
      if ((b_row_r == ROW_LOW) && (int'(pos_r) == b)) begin
        col_low[b] = 1'b0;
      end
      if ((b_row_r == ROW_MID) && (int'(pos_r) + 4 == b)) begin
        col_low[b] = 1'b0;
      end
    end
    for (int b = 0; b < COL_HIGH_W; b++) begin
      if ((b_row_r == ROW_HIGH) && (int'(pos_r) == b)) begin
        col_high[b] = 1'b0;
      end
    end
    out_tdata = {2'b00, segs_r[pos_r], col_high, col_low, DPOS_W'(pos_r)};
  end

  assign out_tvalid = b_valid_r;
  assign out_tlast  = (pos_r == POS_W'(DIGIT_COUNT - 1));

endmodule
